// ===== rtl/cmwc_pkg.sv =====
// Package for the CMWC-4096 random generator: widths, constants,
// the sequencer state type and the shared arithmetic unit's request type.
// No dependencies.
package cmwc_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int POS_W       = $clog2(TABLE_DEPTH);
    localparam int WORD_W      = 32;
    localparam int CARRY_W     = 19;
    localparam int K_W         = 15;              // carry out of one step, max 18783
    localparam int MUL_W       = WORD_W + K_W;    // 18782 * word + carry fits here
    localparam int VALUE_W     = 16;

    localparam logic [WORD_W-1:0]  GOLDEN_STEP   = 32'h9e37_79b9;
    localparam logic [CARRY_W-1:0] CARRY_INIT    = 19'd362436;
    localparam logic [K_W-1:0]     MULTIPLIER    = 15'd18782;
    localparam logic [WORD_W-1:0]  BASE_WORD     = 32'hffff_fffe;
    localparam logic [POS_W-1:0]   POSITION_INIT = POS_W'(4095);
    localparam logic [POS_W-1:0]   POSITION_LAST = POS_W'(TABLE_DEPTH - 1);

    localparam logic ACTION_SEED = 1'b0;
    localparam logic ACTION_NEXT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_MAC,
        ST_FIX
    } state_t;

    typedef enum logic [2:0] {
        ALU_PASS,   // a
        ALU_ADD,    // a + golden step
        ALU_MIX,    // a ^ b ^ golden step ^ idx
        ALU_MAC,    // 18782 * a + b
        ALU_FIX     // carry correction and complement, {k, base - x}
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [WORD_W-1:0]  a;
        logic [WORD_W-1:0]  b;
        logic [POS_W-1:0]   idx;
    } alu_req_t;

endpackage

// ===== rtl/cmwc_random_generator.sv =====
// A next beat goes through multiply-add, then correct and write back, before its value
// is registered; in_ready returns in the cycle the result is registered. A new beat is
// taken only once the last is through; a stalled result holds the block in its last
// step. A seed beat rewrites the whole table, one table word written per cycle.
// Reset (rst_n, async, active low): carry 362436, position 4095, table reads as zero
// until written; no clearing pass is needed.
module cmwc_random_generator
    import cmwc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [WORD_W-1:0]  seed,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] value
);

    // Sequencer state
    state_t state_reg, state_next;

    // Generator state
    logic [POS_W-1:0]   pos_reg;
    logic [CARRY_W-1:0] carry_reg;
    // Set when a seed beat is accepted (its walk rewrites every table word), or once
    // next beats have walked the whole table; before that, reads give zero.
    logic               live_reg;

    // Seed walk: index and the last three words written
    logic [POS_W-1:0]   idx_reg;
    logic [WORD_W-1:0]  seed_reg;
    logic [WORD_W-1:0]  w1_reg, w2_reg, w3_reg;

    // Multiply-add result held between the two arithmetic passes
    logic [MUL_W-1:0]   t_reg;

    // Output register
    logic               out_valid_reg;
    logic [VALUE_W-1:0] value_reg;

    // Datapath
    alu_req_t           alu_req;
    logic [MUL_W-1:0]   alu_res;
    logic               ram_we;
    logic [POS_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [POS_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;
    logic               accept;
    logic               fix_go;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign fix_go    = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    // Lag table
    cmwc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared arithmetic unit
    cmwc_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (action == ACTION_NEXT) ? ST_MAC : ST_SEED;
                end
            end
            ST_SEED:
            begin
                if (idx_reg == POSITION_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MAC:  state_next = ST_FIX;
            ST_FIX:
            begin
                if (fix_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath control. The read address runs one ahead of the position while
    // idle, so the word for a next beat is already being read at acceptance.
    always_comb
    begin
        alu_req   = '{op: ALU_PASS, a: '0, b: '0, idx: idx_reg};
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = alu_res[WORD_W-1:0];
        ram_raddr = pos_reg + POS_W'(1);
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_SEED:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                if (idx_reg == '0)
                begin
                    alu_req.op = ALU_PASS;
                    alu_req.a  = seed_reg;
                end
                else if (idx_reg < POS_W'(3))
                begin
                    alu_req.op = ALU_ADD;
                    alu_req.a  = w1_reg;
                end
                else
                begin
                    alu_req.op = ALU_MIX;
                    alu_req.a  = w3_reg;
                    alu_req.b  = w2_reg;
                end
            end
            ST_MAC:
            begin
                alu_req.op = ALU_MAC;
                alu_req.a  = live_reg ? ram_rdata : '0;
                alu_req.b  = WORD_W'(carry_reg);
            end
            ST_FIX:
            begin
                alu_req.op = ALU_FIX;
                alu_req.a  = t_reg[WORD_W-1:0];
                alu_req.b  = WORD_W'(t_reg[MUL_W-1:WORD_W]);
                ram_we     = fix_go;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= POSITION_INIT;
            carry_reg     <= CARRY_INIT;
            live_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (action == ACTION_NEXT)
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
                else
                begin
                    // whole table is rewritten before any read can happen
                    pos_reg   <= POSITION_INIT;
                    carry_reg <= CARRY_INIT;
                    live_reg  <= 1'b1;
                    idx_reg   <= '0;
                end
            end
            if (state_reg == ST_SEED)
            begin
                idx_reg <= idx_reg + POS_W'(1);
            end
            if (state_reg == ST_FIX && fix_go)
            begin
                carry_reg     <= CARRY_W'(alu_res[MUL_W-1:WORD_W]);
                out_valid_reg <= 1'b1;
                if (pos_reg == POSITION_LAST)
                begin
                    live_reg <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept && action == ACTION_SEED)
        begin
            seed_reg <= seed;
        end
        if (state_reg == ST_SEED)
        begin
            w3_reg <= w2_reg;
            w2_reg <= w1_reg;
            w1_reg <= alu_res[WORD_W-1:0];
        end
        if (state_reg == ST_MAC)
        begin
            t_reg <= alu_res;
        end
        if (state_reg == ST_FIX && fix_go)
        begin
            value_reg <= alu_res[VALUE_W-1:0];
        end
    end

endmodule

// ===== rtl/cmwc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cmwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/cmwc_alu.sv =====
// Shared arithmetic unit of the CMWC generator: seed mixing, multiply-add,
// carry correction. Purely combinational. Depends on cmwc_pkg.
module cmwc_alu
    import cmwc_pkg::*;
(
    input  alu_req_t           req,
    output logic [MUL_W-1:0]   res
);

    logic [WORD_W:0]   fix_sum;
    logic              fix_wrap;
    logic [WORD_W-1:0] fix_x;
    logic [K_W-1:0]    fix_k;

    // x = t_lo + k; a wrap means x < k, so bump both
    always_comb
    begin
        fix_sum  = {1'b0, req.a} + {1'b0, req.b};
        fix_wrap = fix_sum[WORD_W];
        fix_x    = fix_sum[WORD_W-1:0] + WORD_W'(fix_wrap);
        fix_k    = req.b[K_W-1:0] + K_W'(fix_wrap);
    end

    always_comb
    begin
        unique case (req.op)
            ALU_PASS: res = MUL_W'(req.a);
            ALU_ADD:  res = MUL_W'(req.a + GOLDEN_STEP);
            ALU_MIX:  res = MUL_W'(req.a ^ req.b ^ GOLDEN_STEP ^ WORD_W'(req.idx));
            ALU_MAC:  res = MUL_W'(req.a) * MUL_W'(MULTIPLIER) + MUL_W'(req.b);
            ALU_FIX:  res = {fix_k, BASE_WORD - fix_x};
            default:  res = '0;
        endcase
    end

endmodule

// ===== rtl/cmwc_checker.sv =====
// Port-level checker for cmwc_random_generator and its bind.
// Depends on cmwc_pkg and the top level.
module cmwc_checker
    import cmwc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               action,
    input logic               out_valid,
    input logic               out_ready,
    input logic [VALUE_W-1:0] value
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value))
        else $error("result beat changed while stalled");

    // one beat at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after an accepted beat");

    // a seed beat gives no result
    a_seed_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == ACTION_SEED && !out_valid |=> !out_valid)
        else $error("result after a seed beat");

    // results appear only out of a busy cycle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

endmodule

bind cmwc_random_generator cmwc_checker u_cmwc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value)
);
